>>> design/axis_thrust_allocation_with_saturation_macros.svh
// Assertion macros for the thrust allocation block.
`ifndef AXIS_THRUST_ALLOCATION_WITH_SATURATION_MACROS_SVH
`define AXIS_THRUST_ALLOCATION_WITH_SATURATION_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define ATAS_ASSERT_IMPL(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("thrust allocation check failed");

// Next-cycle implication.
`define ATAS_ASSERT_NEXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("thrust allocation check failed");

`else

`define ATAS_ASSERT_IMPL(lbl, ck, rs, ante, cons)
`define ATAS_ASSERT_NEXT(lbl, ck, rs, ante, cons)

`endif

`endif

>>> design/atas_pkg.sv
package atas_pkg;

  // Result count cap and fixed field widths
  localparam int RES_CAP = 4;
  localparam int IDX_W   = 2;
  localparam int DATA_W  = 32;
  localparam int LIM_W   = 31;
  localparam int QUO_W   = 31;
  localparam int CNT_W   = 5;
  localparam int PROD_W  = 64;
  localparam int OPND_W  = 33;
  localparam int ACC_W   = 34;

  // Input codes
  localparam logic ACT_LOAD    = 1'b0;
  localparam logic ACT_COMPUTE = 1'b1;
  localparam logic AXIS_THRUST = 1'b0;
  localparam logic AXIS_YAW    = 1'b1;

  // Configuration register indexes
  localparam logic [1:0] CFG_MOTORS = 2'd0;
  localparam logic [1:0] CFG_THRUST = 2'd1;
  localparam logic [1:0] CFG_YAW    = 2'd2;

  typedef struct packed {
    logic signed [DATA_W-1:0] gain_p;
    logic signed [DATA_W-1:0] gain_i;
    logic signed [DATA_W-1:0] gain_d;
  } gain_row_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_READ,
    S_MUL_P,
    S_MUL_I,
    S_MUL_D,
    S_SUM,
    S_TERM,
    S_CHECK,
    S_SC_MUL,
    S_SC_DIV,
    S_SC_WAIT,
    S_FIN,
    S_OUT
  } state_t;

  // Q16.16 product: floor shift by 16, saturate to 32 bits
  function automatic logic signed [DATA_W-1:0] qsat(input logic signed [PROD_W-1:0] p);
    logic signed [DATA_W-1:0] r;
    if (p[PROD_W-1:47] == {17{p[PROD_W-1]}}) begin
      r = p[47:16];
    end else if (p[PROD_W-1]) begin
      r = 32'sh8000_0000;
    end else begin
      r = 32'sh7fff_ffff;
    end
    return r;
  endfunction

  // Saturate a three-term sum to 32 bits
  function automatic logic signed [DATA_W-1:0] sat_sum(input logic signed [ACC_W-1:0] s);
    logic signed [DATA_W-1:0] r;
    if (s[ACC_W-1:DATA_W-1] == {3{s[ACC_W-1]}}) begin
      r = s[DATA_W-1:0];
    end else if (s[ACC_W-1]) begin
      r = 32'sh8000_0000;
    end else begin
      r = 32'sh7fff_ffff;
    end
    return r;
  endfunction

endpackage

>>> design/atas_gain_mem.sv
module atas_gain_mem
  import atas_pkg::*;
#(
  parameter int ROWS   = 8,
  parameter int ADDR_W = 3
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  gain_row_t         wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output gain_row_t         rd_data
);

  gain_row_t mem [ROWS];
  logic [ROWS-1:0] row_valid;

  // Track written rows; unwritten rows read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
    end else if (wr_en) begin
      row_valid[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port, holds when not enabled
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= row_valid[rd_addr] ? mem[rd_addr] : '0;
    end
  end

endmodule

>>> design/atas_mul.sv
module atas_mul
  import atas_pkg::*;
(
  input  logic                     clk,
  input  logic                     en,
  input  logic signed [OPND_W-1:0] a,
  input  logic signed [OPND_W-1:0] b,
  output logic signed [PROD_W-1:0] prod
);

  logic signed [2*OPND_W-1:0] full;

  assign full = a * b;

  // Register the product; operands never need more than 64 result bits
  always_ff @(posedge clk) begin
    if (en) begin
      prod <= full[PROD_W-1:0];
    end
  end

endmodule

>>> design/atas_divider.sv
module atas_divider
  import atas_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [PROD_W-2:0]      dividend,
  input  logic [DATA_W-1:0]      divisor,
  output logic                   busy,
  output logic                   done,
  output logic [QUO_W-1:0]       quot
);

  logic [DATA_W-1:0] rem;
  logic [QUO_W-1:0]  shreg;
  logic [DATA_W-1:0] dvs;
  logic [CNT_W-1:0]  cnt;
  logic [DATA_W:0]   trial;
  logic [DATA_W:0]   diff;
  logic              qbit;

  // One restoring step: bring down a bit, subtract if it fits
  assign trial = {rem, shreg[QUO_W-1]};
  assign diff  = trial - {1'b0, dvs};
  assign qbit  = (trial >= {1'b0, dvs});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(QUO_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Quotient is known to fit in 31 bits, so the top bits seed the remainder
  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= dividend[PROD_W-2:QUO_W];
      shreg <= dividend[QUO_W-1:0];
      dvs   <= divisor;
    end else if (busy) begin
      rem   <= qbit ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
      shreg <= {shreg[QUO_W-2:0], 1'b0};
      quot  <= {quot[QUO_W-2:0], qbit};
    end
  end

endmodule

>>> design/axis_thrust_allocation_with_saturation.sv
// Channel  Direction  Handshake              Word
// in       input      in_valid / in_ready    action, axis, motor_sel, gains, errors
// out      output     out_valid / out_ready  motor_out, thrust_term, last_motor,
//                                            hold_integral, yaw_candidate
// cfg      input      cfg_wr_en              cfg_index, cfg_data
//
// A load word only writes the gain table. A compute word takes each motor through
// the read, multiply, sum and term states, then gives one output word per motor; when
// the limit is exceeded each motor is also scaled by the shared multiplier and the one-bit-a-cycle divider.
// in_ready is high only while the sequencer is idle; one word is worked at a time.
// The output register lets a new word enter while the last result waits.
// Reset is synchronous; gains read as zero until loaded.
`include "axis_thrust_allocation_with_saturation_macros.svh"

module axis_thrust_allocation_with_saturation
  import atas_pkg::*;
#(
  parameter int MAX_MOTORS = 4
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     action,
  input  logic                     axis,
  input  logic [1:0]               motor_sel,
  input  logic signed [DATA_W-1:0] gain_prop,
  input  logic signed [DATA_W-1:0] gain_integ,
  input  logic signed [DATA_W-1:0] gain_deriv,
  input  logic signed [DATA_W-1:0] err_prop,
  input  logic signed [DATA_W-1:0] err_integ,
  input  logic signed [DATA_W-1:0] err_deriv,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [IDX_W-1:0]         motor_out,
  output logic signed [DATA_W-1:0] thrust_term,
  output logic                     last_motor,
  output logic                     hold_integral,
  output logic signed [DATA_W-1:0] yaw_candidate,
  input  logic                     cfg_wr_en,
  input  logic [1:0]               cfg_index,
  input  logic [LIM_W-1:0]         cfg_data
);

  localparam int MOT_W  = (MAX_MOTORS > 1) ? $clog2(MAX_MOTORS) : 1;
  localparam int ROWS   = 2 * MAX_MOTORS;
  localparam int ADDR_W = MOT_W + 1;
  localparam int SEL_W  = MOT_W + 2;
  localparam int CAP    = (MAX_MOTORS < RES_CAP) ? MAX_MOTORS : RES_CAP;

  state_t state, state_next;

  // Configuration
  logic [2:0]       motors_in_use;
  logic [LIM_W-1:0] thrust_limit;
  logic [LIM_W-1:0] yaw_limit;

  // Item context
  logic                     axis_r;
  logic signed [DATA_W-1:0] ep, ei, ed;
  logic [IDX_W-1:0]         n_last;
  logic [IDX_W-1:0]         idx;
  logic [LIM_W-1:0]         limit_r;
  logic signed [ACC_W-1:0]  acc;
  logic signed [DATA_W-1:0] term_r;
  logic [DATA_W-1:0]        maxabs;
  logic signed [DATA_W-1:0] best_d;
  logic [IDX_W-1:0]         best_idx;
  logic                     found;
  logic signed [DATA_W-1:0] cand;
  logic signed [DATA_W-1:0] held_yaw_candidate;
  logic                     hold_r;
  logic                     neg_r;
  logic signed [DATA_W-1:0] term_buffer [RES_CAP];

  // Handshake and unit control
  logic                     in_acc;
  logic                     out_load;
  logic                     last;
  logic                     gm_wr_en;
  logic [SEL_W-1:0]         sel_wide;
  gain_row_t                gm_wr_data;
  logic                     gm_rd_en;
  logic [ADDR_W-1:0]        gm_rd_addr;
  gain_row_t                row;
  logic                     mul_en;
  logic signed [OPND_W-1:0] mul_a, mul_b;
  logic signed [PROD_W-1:0] prod;
  logic                     div_start;
  logic                     div_busy;
  logic                     div_done;
  logic [QUO_W-1:0]         quot;
  logic [2:0]               n_eff;
  logic [DATA_W-1:0]        abs_term;
  logic signed [DATA_W-1:0] buf_rd;
  logic [DATA_W-1:0]        buf_abs;
  logic signed [DATA_W-1:0] scaled;
  logic signed [DATA_W-1:0] pq;

  assign in_acc   = in_valid && in_ready;
  assign out_load = (state == S_OUT) && (!out_valid || out_ready);
  assign last     = (idx == n_last);
  assign pq       = qsat(prod);
  assign abs_term = term_r[DATA_W-1] ? (~term_r + 1'b1) : term_r;
  assign buf_rd   = term_buffer[idx];
  assign buf_abs  = buf_rd[DATA_W-1] ? (~buf_rd + 1'b1) : buf_rd;
  assign scaled   = neg_r ? -$signed({1'b0, quot}) : $signed({1'b0, quot});

  // Clamp motor count to 1..CAP
  always_comb begin
    if (motors_in_use == 3'd0) begin
      n_eff = 3'd1;
    end else if (motors_in_use > 3'(CAP)) begin
      n_eff = 3'(CAP);
    end else begin
      n_eff = motors_in_use;
    end
  end

  // Gain load path; drop loads to motors beyond the table
  assign sel_wide   = SEL_W'(motor_sel);
  assign gm_wr_en   = in_acc && (action == ACT_LOAD) && (sel_wide < SEL_W'(MAX_MOTORS));
  assign gm_wr_data = '{gain_p: gain_prop, gain_i: gain_integ, gain_d: gain_deriv};

  atas_gain_mem #(
    .ROWS   (ROWS),
    .ADDR_W (ADDR_W)
  ) u_gain_mem (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (gm_wr_en),
    .wr_addr ({sel_wide[MOT_W-1:0], axis}),
    .wr_data (gm_wr_data),
    .rd_en   (gm_rd_en),
    .rd_addr (gm_rd_addr),
    .rd_data (row)
  );

  atas_mul u_mul (
    .clk  (clk),
    .en   (mul_en),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  atas_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (prod[PROD_W-2:0]),
    .divisor  (maxabs),
    .busy     (div_busy),
    .done     (div_done),
    .quot     (quot)
  );

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:    if (in_acc && action == ACT_COMPUTE) state_next = S_READ;
      S_READ:    state_next = S_MUL_P;
      S_MUL_P:   state_next = S_MUL_I;
      S_MUL_I:   state_next = S_MUL_D;
      S_MUL_D:   state_next = S_SUM;
      S_SUM:     state_next = S_TERM;
      S_TERM:    state_next = last ? S_CHECK : S_READ;
      S_CHECK:   state_next = (maxabs > {1'b0, limit_r}) ? S_SC_MUL : S_FIN;
      S_SC_MUL:  state_next = S_SC_DIV;
      S_SC_DIV:  state_next = S_SC_WAIT;
      S_SC_WAIT: if (div_done) state_next = last ? S_FIN : S_SC_MUL;
      S_FIN:     state_next = S_OUT;
      S_OUT:     if (out_load && last) state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  // Unit controls per state
  always_comb begin
    in_ready   = 1'b0;
    gm_rd_en   = 1'b0;
    gm_rd_addr = {MOT_W'(idx), axis_r};
    mul_en     = 1'b0;
    mul_a      = OPND_W'(row.gain_p);
    mul_b      = OPND_W'(ep);
    div_start  = 1'b0;
    unique case (state)
      S_IDLE:  in_ready = 1'b1;
      S_READ:  gm_rd_en = 1'b1;
      S_MUL_P: mul_en = 1'b1;
      S_MUL_I: begin
        mul_en = 1'b1;
        mul_a  = OPND_W'(row.gain_i);
        mul_b  = OPND_W'(ei);
      end
      S_MUL_D: begin
        mul_en = 1'b1;
        mul_a  = OPND_W'(row.gain_d);
        mul_b  = OPND_W'(ed);
      end
      S_SC_MUL: begin
        mul_en = 1'b1;
        mul_a  = $signed({1'b0, buf_abs});
        mul_b  = $signed({2'b00, limit_r});
      end
      S_SC_DIV: div_start = 1'b1;
      default: ;
    endcase
  end

  // Control registers and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= S_IDLE;
      motors_in_use      <= 3'd4;
      thrust_limit       <= '1;
      yaw_limit          <= '1;
      out_valid          <= 1'b0;
      held_yaw_candidate <= '0;
    end else begin
      state <= state_next;
      if (cfg_wr_en) begin
        unique case (cfg_index)
          CFG_MOTORS: motors_in_use <= cfg_data[2:0];
          CFG_THRUST: thrust_limit  <= cfg_data;
          CFG_YAW:    yaw_limit     <= cfg_data;
          default: ;
        endcase
      end
      // Commit the yaw pick once all terms are final
      if (state == S_FIN && axis_r == AXIS_YAW && found) begin
        held_yaw_candidate <= cand;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (in_acc) begin
          axis_r  <= axis;
          ep      <= err_prop;
          ei      <= err_integ;
          ed      <= err_deriv;
          n_last  <= IDX_W'(n_eff - 3'd1);
          limit_r <= (axis == AXIS_YAW) ? yaw_limit : thrust_limit;
          idx     <= '0;
          maxabs  <= '0;
          best_d  <= '0;
          found   <= 1'b0;
        end
      end
      S_MUL_I: acc <= ACC_W'(pq);
      S_MUL_D: acc <= acc + ACC_W'(pq);
      S_SUM:   term_r <= sat_sum(acc + ACC_W'(pq));
      S_TERM: begin
        term_buffer[idx] <= term_r;
        if (abs_term > maxabs) begin
          maxabs <= abs_term;
        end
        // First motor with the largest positive D gain wins
        if (axis_r == AXIS_YAW && row.gain_d > best_d) begin
          best_d   <= row.gain_d;
          best_idx <= idx;
          found    <= 1'b1;
          cand     <= term_r;
        end
        if (!last) begin
          idx <= idx + 1'b1;
        end
      end
      S_CHECK: begin
        hold_r <= (maxabs > {1'b0, limit_r});
        idx    <= '0;
      end
      S_SC_MUL: neg_r <= buf_rd[DATA_W-1];
      S_SC_WAIT: begin
        if (div_done) begin
          term_buffer[idx] <= scaled;
          if (found && best_idx == idx) begin
            cand <= scaled;
          end
          if (!last) begin
            idx <= idx + 1'b1;
          end
        end
      end
      S_FIN: idx <= '0;
      S_OUT: begin
        if (out_load) begin
          motor_out     <= idx;
          thrust_term   <= buf_rd;
          last_motor    <= last;
          hold_integral <= hold_r;
          yaw_candidate <= (last && axis_r == AXIS_YAW) ? held_yaw_candidate : '0;
          if (!last) begin
            idx <= idx + 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  // Checks
  `ATAS_ASSERT_IMPL(a_ready_div_idle, clk, rst, in_ready, !div_busy)
  `ATAS_ASSERT_IMPL(a_scale_on_hold, clk, rst, div_start, hold_r)
  `ATAS_ASSERT_IMPL(a_cand_on_last, clk, rst, out_valid && !last_motor, yaw_candidate == '0)
  `ATAS_ASSERT_NEXT(a_last_ends_word, clk, rst, out_load && last, state == S_IDLE)

endmodule

>>> bench/tb_axis_thrust_allocation_with_saturation.sv
module tb_axis_thrust_allocation_with_saturation;
  import atas_pkg::*;

  localparam int STALL_LIMIT = 5000;
  localparam int SETTLE      = 40;
  localparam int LONG_HOLD   = 300;
  localparam int MOTORS      = 4;

  typedef struct {
    logic                     action;
    logic                     axis;
    logic [1:0]               motor_sel;
    logic signed [DATA_W-1:0] gain_p;
    logic signed [DATA_W-1:0] gain_i;
    logic signed [DATA_W-1:0] gain_d;
    logic signed [DATA_W-1:0] err_p;
    logic signed [DATA_W-1:0] err_i;
    logic signed [DATA_W-1:0] err_d;
  } alloc_word_t;

  typedef struct {
    logic [IDX_W-1:0]         motor;
    logic signed [DATA_W-1:0] term;
    logic                     last;
    logic                     hold;
    logic signed [DATA_W-1:0] yaw;
  } alloc_result_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic                     action = 1'b0;
  logic                     axis = 1'b0;
  logic [1:0]               motor_sel = 2'd0;
  logic signed [DATA_W-1:0] gain_prop = '0;
  logic signed [DATA_W-1:0] gain_integ = '0;
  logic signed [DATA_W-1:0] gain_deriv = '0;
  logic signed [DATA_W-1:0] err_prop = '0;
  logic signed [DATA_W-1:0] err_integ = '0;
  logic signed [DATA_W-1:0] err_deriv = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic [IDX_W-1:0]         motor_out;
  logic signed [DATA_W-1:0] thrust_term;
  logic                     last_motor;
  logic                     hold_integral;
  logic signed [DATA_W-1:0] yaw_candidate;
  logic                     cfg_wr_en = 1'b0;
  logic [1:0]               cfg_index = 2'd0;
  logic [LIM_W-1:0]         cfg_data = '0;

  axis_thrust_allocation_with_saturation #(.MAX_MOTORS(MOTORS)) u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .action(action), .axis(axis), .motor_sel(motor_sel),
    .gain_prop(gain_prop), .gain_integ(gain_integ), .gain_deriv(gain_deriv),
    .err_prop(err_prop), .err_integ(err_integ), .err_deriv(err_deriv),
    .out_valid(out_valid), .out_ready(out_ready),
    .motor_out(motor_out), .thrust_term(thrust_term), .last_motor(last_motor),
    .hold_integral(hold_integral), .yaw_candidate(yaw_candidate),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  // Shadow copy of the allocator state
  logic signed [DATA_W-1:0] gain_mem [MOTORS][2][3];
  logic signed [DATA_W-1:0] held_yaw;
  logic [2:0]               cfg_motors;
  logic [LIM_W-1:0]         cfg_thrust_lim;
  logic [LIM_W-1:0]         cfg_yaw_lim;

  alloc_word_t   pending_words[$];
  alloc_result_t expected_terms[$];
  alloc_word_t   cur;
  alloc_result_t want;
  int            fails = 0;
  int            res_count = 0;

  function automatic longint clamp32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // Q16.16 multiply: floor shift, then saturate
  function automatic longint q16_mul(input logic signed [DATA_W-1:0] a,
                                     input logic signed [DATA_W-1:0] b);
    longint p;
    p = longint'(a) * longint'(b);
    return clamp32(p >>> 16);
  endfunction

  // Update the table on a load; compute the per-motor results on a compute
  task automatic predict_alloc(input alloc_word_t w);
    int                       n;
    longint                   s, t, a, maxabs, lim, best_d;
    logic signed [DATA_W-1:0] terms [MOTORS];
    logic                     hold;
    alloc_result_t            r;
    if (w.action == ACT_LOAD) begin
      gain_mem[w.motor_sel][w.axis][0] = w.gain_p;
      gain_mem[w.motor_sel][w.axis][1] = w.gain_i;
      gain_mem[w.motor_sel][w.axis][2] = w.gain_d;
      return;
    end
    n = int'(cfg_motors);
    if (n < 1) n = 1;
    if (n > MOTORS) n = MOTORS;
    if (n > RES_CAP) n = RES_CAP;
    maxabs = 0;
    for (int i = 0; i < n; i++) begin
      s = q16_mul(gain_mem[i][w.axis][0], w.err_p)
        + q16_mul(gain_mem[i][w.axis][1], w.err_i)
        + q16_mul(gain_mem[i][w.axis][2], w.err_d);
      t = clamp32(s);
      a = (t < 0) ? -t : t;
      terms[i] = t[DATA_W-1:0];
      if (a > maxabs) maxabs = a;
    end
    lim = (w.axis == AXIS_YAW) ? longint'(cfg_yaw_lim) : longint'(cfg_thrust_lim);
    hold = (maxabs > lim);
    // Scale toward zero by limit/max
    if (hold) begin
      for (int i = 0; i < n; i++) begin
        t = (longint'(terms[i]) * lim) / maxabs;
        terms[i] = t[DATA_W-1:0];
      end
    end
    // Pick the first motor with the largest positive yaw D gain
    if (w.axis == AXIS_YAW) begin
      best_d = 0;
      for (int i = 0; i < n; i++) begin
        if (longint'(gain_mem[i][AXIS_YAW][2]) > best_d) begin
          best_d = longint'(gain_mem[i][AXIS_YAW][2]);
          held_yaw = terms[i];
        end
      end
    end
    for (int i = 0; i < n; i++) begin
      r.motor = i[IDX_W-1:0];
      r.term  = terms[i];
      r.last  = (i == n - 1);
      r.hold  = hold;
      r.yaw   = (r.last && w.axis == AXIS_YAW) ? held_yaw : '0;
      expected_terms.insert(expected_terms.size(), r);
    end
  endtask

  function automatic logic signed [DATA_W-1:0] rand_q();
    case ($urandom_range(0, 7))
      0: return 32'sh7fff_ffff;
      1: return 32'sh8000_0000;
      2, 3, 4: return $urandom();
      default: return $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
    endcase
  endfunction

  task automatic push_load(input logic [1:0] m, input logic ax,
                           input logic signed [DATA_W-1:0] gp, gi, gd);
    alloc_word_t w;
    w.action = ACT_LOAD;
    w.axis = ax;
    w.motor_sel = m;
    w.gain_p = gp;
    w.gain_i = gi;
    w.gain_d = gd;
    w.err_p = $urandom();
    w.err_i = $urandom();
    w.err_d = $urandom();
    pending_words.insert(pending_words.size(), w);
  endtask

  task automatic push_comp(input logic ax, input logic signed [DATA_W-1:0] ep, ei, ed);
    alloc_word_t w;
    w.action = ACT_COMPUTE;
    w.axis = ax;
    w.motor_sel = 2'($urandom_range(0, 3));
    w.gain_p = $urandom();
    w.gain_i = $urandom();
    w.gain_d = $urandom();
    w.err_p = ep;
    w.err_i = ei;
    w.err_d = ed;
    pending_words.insert(pending_words.size(), w);
  endtask

  task automatic push_random();
    logic ax;
    ax = ($urandom_range(0, 1) == 1) ? AXIS_YAW : AXIS_THRUST;
    if ($urandom_range(0, 99) < 35)
      push_load(2'($urandom_range(0, 3)), ax, rand_q(), rand_q(), rand_q());
    else
      push_comp(ax, rand_q(), rand_q(), rand_q());
  endtask

  // Wait until every word is taken and every result is back, then settle
  task automatic drain();
    while (pending_words.size() != 0 || in_valid || expected_terms.size() != 0)
      @(negedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [LIM_W-1:0] data);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      CFG_MOTORS: cfg_motors = data[2:0];
      CFG_THRUST: cfg_thrust_lim = data;
      CFG_YAW:    cfg_yaw_lim = data;
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [2:0] m, input logic [LIM_W-1:0] tl, yl);
    drain();
    write_reg(CFG_MOTORS, {{(LIM_W-3){1'b0}}, m});
    write_reg(CFG_THRUST, tl);
    write_reg(CFG_YAW, yl);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Driver: bursts of words with random gaps
  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) predict_alloc(cur);
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_words.size() > 0) begin
          cur = pending_words.pop_front();
          action     <= cur.action;
          axis       <= cur.axis;
          motor_sel  <= cur.motor_sel;
          gain_prop  <= cur.gain_p;
          gain_integ <= cur.gain_i;
          gain_deriv <= cur.gain_d;
          err_prop   <= cur.err_p;
          err_integ  <= cur.err_i;
          err_deriv  <= cur.err_d;
          in_valid   <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 15);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random ready patterns plus an occasional long hold-off
  int rx_mode = 0;
  int mode_left = 0;
  int hold_left = 0;
  int next_long = 150;

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (res_count >= next_long) begin
      hold_left = LONG_HOLD;
      next_long = next_long + 300;
      out_ready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        rx_mode = $urandom_range(0, 3);
        mode_left = $urandom_range(10, 80);
      end else begin
        mode_left--;
      end
      case (rx_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= ($urandom_range(0, 1) == 1);
        2: out_ready <= ($urandom_range(0, 7) != 0);
        default: out_ready <= ($urandom_range(0, 5) == 0);
      endcase
    end
  end

  task automatic check_field(input string name, input logic [DATA_W-1:0] exp_v,
                             input logic [DATA_W-1:0] got_v);
    if (got_v !== exp_v) begin
      $error("%s: expected 0x%08h, got 0x%08h", name, exp_v, got_v);
      fails++;
    end
  endtask

  // Monitor: compare each result word with the oldest expectation
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      res_count <= res_count + 1;
      if (expected_terms.size() == 0) begin
        $error("unexpected result word for motor %0d", motor_out);
        fails++;
      end else begin
        want = expected_terms.pop_front();
        check_field("motor_out", DATA_W'(want.motor), DATA_W'(motor_out));
        check_field("thrust_term", want.term, thrust_term);
        check_field("last_motor", DATA_W'(want.last), DATA_W'(last_motor));
        check_field("hold_integral", DATA_W'(want.hold), DATA_W'(hold_integral));
        check_field("yaw_candidate", want.yaw, yaw_candidate);
      end
    end
  end

  // Watchdog: stop when nothing moves for too long
  int idle_cycles = 0;

  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_wr_en)
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  initial begin
    cfg_motors = 3'd4;
    cfg_thrust_lim = 31'h7fff_ffff;
    cfg_yaw_lim = 31'h7fff_ffff;
    held_yaw = '0;
    for (int m = 0; m < MOTORS; m++)
      for (int a = 0; a < 2; a++)
        for (int g = 0; g < 3; g++)
          gain_mem[m][a][g] = '0;

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Zero gains: all terms zero, no positive D gain on yaw
    push_comp(AXIS_THRUST, 32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff);
    push_comp(AXIS_YAW, 32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000);
    // Extreme gains on thrust: product and sum saturation
    push_load(2'd0, AXIS_THRUST, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff);
    push_load(2'd1, AXIS_THRUST, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
    push_load(2'd2, AXIS_THRUST, 32'sh0001_0000, -32'sh0001_0000, 32'sh0);
    push_load(2'd3, AXIS_THRUST, 32'sh1, -32'sh1, 32'sh0000_8000);
    push_comp(AXIS_THRUST, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff);
    push_comp(AXIS_THRUST, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
    push_comp(AXIS_THRUST, -32'sh1, 32'sh1, 32'sh0001_0000);
    // Yaw with no positive D gain: candidate keeps its value
    push_load(2'd0, AXIS_YAW, 32'sh0001_0000, 32'sh0, -32'sh5);
    push_load(2'd1, AXIS_YAW, 32'sh0002_0000, 32'sh0, 32'sh0);
    push_load(2'd2, AXIS_YAW, 32'sh0003_0000, 32'sh0, 32'sh8000_0000);
    push_load(2'd3, AXIS_YAW, 32'sh0004_0000, 32'sh0, -32'sh1);
    push_comp(AXIS_YAW, 32'sh0001_0000, 32'sh0, 32'sh0001_0000);
    // Tie on the largest D gain: the first motor wins
    push_load(2'd2, AXIS_YAW, 32'sh0003_0000, 32'sh0, 32'sh0002_0000);
    push_load(2'd3, AXIS_YAW, 32'sh0004_0000, 32'sh0, 32'sh0002_0000);
    push_comp(AXIS_YAW, 32'sh0001_8000, 32'sh0000_0100, 32'sh0001_0000);
    // Drop the positive D gains again: previous candidate is repeated
    push_load(2'd2, AXIS_YAW, 32'sh0003_0000, 32'sh0, -32'sh1);
    push_load(2'd3, AXIS_YAW, 32'sh0004_0000, 32'sh0, -32'sh1);
    push_comp(AXIS_YAW, 32'sh0005_0000, 32'sh0, 32'sh0);

    // One motor, term equal to the limit, then just above it, then a negative term at twice it
    set_config(3'd1, 31'h0003_0000, 31'h0003_0000);
    push_load(2'd0, AXIS_THRUST, 32'sh0001_0000, 32'sh0, 32'sh0);
    push_comp(AXIS_THRUST, 32'sh0003_0000, 32'sh0, 32'sh0);
    push_comp(AXIS_THRUST, 32'sh0003_0001, 32'sh0, 32'sh0);
    push_comp(AXIS_THRUST, -32'sh0006_0000, 32'sh0, 32'sh0);

    // Random phases over a spread of settings
    for (int p = 0; p < 8; p++) begin
      case (p)
        0: set_config(3'd2, LIM_W'($urandom_range(0, 32'h7fff_ffff)),
                      LIM_W'($urandom_range(0, 32'h7fff_ffff)));
        1: set_config(3'd3, 31'h7fff_ffff, LIM_W'($urandom_range(0, 32'h0010_0000)));
        2: set_config(3'd0, LIM_W'($urandom_range(0, 32'h0004_0000)), 31'h7fff_ffff);
        3: set_config(3'd4, 31'h0, 31'h7fff_ffff);
        4: set_config(3'd7, LIM_W'($urandom_range(0, 32'h0010_0000)),
                      LIM_W'($urandom_range(0, 32'h0010_0000)));
        5: set_config(3'd5, 31'h7fff_ffff, 31'h0);
        6: set_config(3'd1, LIM_W'($urandom_range(0, 32'h7fff_ffff)), 31'h1);
        default: set_config(3'd4, 31'h7fff_ffff, 31'h7fff_ffff);
      endcase
      repeat (38) push_random();
    end

    drain();
    if (fails == 0 && expected_terms.size() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
